// ===== sv/usq_pkg.sv =====
// Shared constants and register codes for the uniform scalar quantizer.
`default_nettype none
package usq_pkg;

	// Grey range and the one-to-one mode corner
	localparam logic [7:0] GREY_MAX    = 8'd255;
	localparam logic [7:0] FULL_LEVELS = 8'd255;
	localparam logic [7:0] DIRECT_TOP  = 8'd254;

	// Register reset values
	localparam logic [7:0] LEVEL_COUNT_RST = 8'd32;
	localparam logic [7:0] TOP_VALUE_RST   = 8'd255;

	// Register indexes (paddr[2])
	localparam logic REG_LEVEL_COUNT = 1'b0;
	localparam logic REG_TOP_VALUE   = 1'b1;

	// Output queue depth and table geometry
	localparam int FIFO_DEPTH = 4;
	localparam int TBL_DEPTH  = 256;
	localparam int DIV_STEPS  = 8;

	// Result item as carried in m_tdata
	typedef struct packed {
		logic [7:0] reconstructed_value;
		logic [7:0] level_index;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/uniform_scalar_quantiser.sv =====
// Uniform scalar quantizer: table-driven index and midpoint lookup per grey sample.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------------
//   s_*      | in        | tdata[10:0] sample (signed), [15:11] zero
//   m_*      | out       | tdata[7:0] level_index, [15:8] reconstructed_value
//   APB      | in/out    | 0x0 level_count, 0x4 top_value (bits [7:0])
//
// One item per clock while s_tready is high. An accepted item takes the index table
// read at the accepting edge, the midpoint table read, then the output queue write.
// After reset and after every register write the two 256-entry tables are rebuilt:
// a load step, two 8-step serial divisions, then a fill sweep over all 256 entries,
// with s_tready low. A 4-entry output queue absorbs m_tready stalls; s_tready drops
// when the queue plus the items in flight fill it.
`default_nettype none
module uniform_scalar_quantiser
	import usq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [10:0] sample, [15:11] zero
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata    // [7:0] level_index, [15:8] reconstructed_value
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV1,
		ST_DIV2,
		ST_FILL,
		ST_RUN
	} seq_state_t;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int TA_W  = $clog2(TBL_DEPTH);
	localparam int DC_W  = $clog2(DIV_STEPS);

	// configuration registers
	logic [7:0] level_count_q;
	logic [7:0] top_value_q;
	logic       cfg_wr;

	// sequencer and divider
	seq_state_t state_q;
	logic [8:0] dv_rem_q;
	logic [7:0] dv_quo_q;
	logic [DC_W-1:0] dv_cnt_q;
	logic [9:0] dv_shift;
	logic [8:0] dv_divisor;
	logic       dv_ge;
	logic [8:0] dv_rem_nx;
	logic [7:0] dv_quo_nx;

	// quotients from the divisions: n/top and top/(2n)
	logic [7:0] q1_q;
	logic [7:0] r1_q;
	logic [7:0] q2h_q;
	logic [8:0] r2h_q;

	// fill walk
	logic [TA_W-1:0] fc_q;
	logic [7:0] ix_q;
	logic [7:0] acc_q;
	logic [7:0] rc_q;
	logic [8:0] rm_q;

	logic [7:0] n_eff;
	logic       direct;
	logic       r2h_hi;
	logic [7:0] q2;
	logic [8:0] r2;
	logic [8:0] acc_sum;
	logic       acc_cy;
	logic [9:0] rm_sum;
	logic       rm_cy;
	logic [9:0] two_n;
	logic [7:0] idx_wd;
	logic [7:0] rec_wd;
	logic       tbl_we;

	// tables
	logic [7:0] idx_mem [TBL_DEPTH];
	logic [7:0] rec_mem [TBL_DEPTH];

	// datapath
	logic       s_acc;
	logic [7:0] v_clamp;
	logic       vld_s1;
	logic       vld_s2;
	logic [7:0] idx_s1;
	logic [7:0] idx_s2;
	logic [7:0] rec_s2;

	// output queue
	result_t         fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic            push;
	logic            pop;
	logic [CNT_W-1:0] occupancy;

	// APB decode
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = 32'd0;
		case (paddr[2])
			REG_LEVEL_COUNT: prdata = {24'd0, level_count_q};
			REG_TOP_VALUE:   prdata = {24'd0, top_value_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= LEVEL_COUNT_RST;
			top_value_q   <= TOP_VALUE_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LEVEL_COUNT: level_count_q <= pwdata[7:0];
				REG_TOP_VALUE:   top_value_q   <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	// effective level count and the one-to-one mode
	assign n_eff  = (level_count_q == 8'd0) ? FULL_LEVELS : level_count_q;
	assign direct = (n_eff == FULL_LEVELS) && (top_value_q == DIRECT_TOP);

	// one restoring division step, shared by both divisions
	assign dv_divisor = (state_q == ST_DIV2) ? {n_eff, 1'b0} : {1'b0, top_value_q};
	assign dv_shift   = {dv_rem_q, dv_quo_q[7]};
	assign dv_ge      = dv_shift >= {1'b0, dv_divisor};
	assign dv_rem_nx  = dv_ge ? 9'(dv_shift - {1'b0, dv_divisor}) : dv_shift[8:0];
	assign dv_quo_nx  = {dv_quo_q[6:0], dv_ge};

	// midpoint step: top/n = 2*q2h + (r2h >= n), and 2*(top mod n)
	assign r2h_hi = r2h_q >= {1'b0, n_eff};
	assign q2     = 8'({q2h_q, 1'b0} + {8'd0, r2h_hi});
	assign r2     = r2h_hi ? 9'({r2h_q[7:0], 1'b0} - {n_eff, 1'b0}) : {r2h_q[7:0], 1'b0};
	assign two_n  = {1'b0, n_eff, 1'b0};

	// index walk: v*n/top grows by q1 and a carry of the remainder
	assign acc_sum = {1'b0, acc_q} + {1'b0, r1_q};
	assign acc_cy  = acc_sum >= {1'b0, top_value_q};
	assign rm_sum  = {1'b0, rm_q} + {1'b0, r2};
	assign rm_cy   = rm_sum >= two_n;

	// table entries at the sweep address
	always_comb begin
		if (direct) begin
			idx_wd = (fc_q == GREY_MAX) ? DIRECT_TOP : fc_q;
			rec_wd = fc_q;
		end else begin
			idx_wd = (fc_q >= top_value_q) ? 8'(n_eff - 8'd1) : ix_q;
			rec_wd = rc_q;
		end
	end
	assign tbl_we = (state_q == ST_FILL);

	// sequencer: load, two divisions, fill sweep, run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
			dv_cnt_q <= '0;
			q1_q     <= '0;
			r1_q     <= '0;
			q2h_q    <= '0;
			r2h_q    <= '0;
			fc_q     <= '0;
			ix_q     <= '0;
			acc_q    <= '0;
			rc_q     <= '0;
			rm_q     <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					dv_rem_q <= '0;
					dv_quo_q <= n_eff;
					dv_cnt_q <= '0;
					state_q  <= ST_DIV1;
				end
				ST_DIV1: begin
					dv_rem_q <= dv_rem_nx;
					dv_quo_q <= dv_quo_nx;
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_cnt_q == DC_W'(DIV_STEPS - 1)) begin
						q1_q     <= dv_quo_nx;
						r1_q     <= dv_rem_nx[7:0];
						dv_rem_q <= '0;
						dv_quo_q <= top_value_q;
						state_q  <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					dv_rem_q <= dv_rem_nx;
					dv_quo_q <= dv_quo_nx;
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_cnt_q == DC_W'(DIV_STEPS - 1)) begin
						q2h_q   <= dv_quo_nx;
						r2h_q   <= dv_rem_nx;
						fc_q    <= '0;
						ix_q    <= '0;
						acc_q   <= '0;
						rc_q    <= dv_quo_nx;
						rm_q    <= dv_rem_nx;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					fc_q  <= fc_q + 1'b1;
					ix_q  <= 8'(ix_q + q1_q + {7'd0, acc_cy});
					acc_q <= acc_cy ? 8'(acc_sum - {1'b0, top_value_q}) : acc_sum[7:0];
					rc_q  <= 8'(rc_q + q2 + {7'd0, rm_cy});
					rm_q  <= rm_cy ? 9'(rm_sum - two_n) : rm_sum[8:0];
					if (fc_q == TA_W'(TBL_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// clamp the sample to 0..255
	always_comb begin
		if (s_tdata[10]) begin
			v_clamp = 8'd0;
		end else if (s_tdata[9:8] != 2'd0) begin
			v_clamp = GREY_MAX;
		end else begin
			v_clamp = s_tdata[7:0];
		end
	end

	// admit an item only if the queue has room for everything in flight
	assign occupancy = cnt_q + CNT_W'(vld_s1) + CNT_W'(vld_s2);
	assign s_tready  = (state_q == ST_RUN) && (occupancy < CNT_W'(FIFO_DEPTH));
	assign s_acc     = s_tvalid & s_tready;

	// index table: written by the sweep, read by the sample
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			idx_mem[fc_q] <= idx_wd;
		end
		idx_s1 <= idx_mem[v_clamp];
	end

	// midpoint table: written by the sweep, read by the index
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			rec_mem[fc_q] <= rec_wd;
		end
		rec_s2 <= rec_mem[idx_s1];
		idx_s2 <= idx_s1;
	end

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= s_acc;
			vld_s2 <= vld_s1;
		end
	end

	// output queue
	assign push     = vld_s2;
	assign pop      = m_tvalid & m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{reconstructed_value: rec_s2, level_index: idx_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire
